// ===== hdl/hlst_pkg.sv =====
`timescale 1ns / 1ps

package hlst_pkg;

    localparam int HOP_DEPTH    = 64;
    localparam int HOP_W        = $clog2(HOP_DEPTH);
    localparam int HIST_DEPTH   = 64;
    localparam int SLOT_W       = $clog2(HIST_DEPTH);
    localparam int HIST_ENTRIES = HOP_DEPTH * HIST_DEPTH;
    localparam int HIST_ADDR_W  = HOP_W + SLOT_W;
    localparam int LAT_W        = 24;
    localparam int CNT_W        = 32;
    localparam int SUM_W        = 48;
    localparam int ADDR_W       = 32;
    localparam int TYPE_W       = 8;
    localparam int CMD_W        = 3;
    localparam int DEEP_W       = HOP_W + 1;

    localparam logic [TYPE_W-1:0] DEST_REACHED_TYPE = 8'd3;
    localparam logic [DEEP_W-1:0] MAX_HOPS_RESET    = 7'd30;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROUND_START = 3'd0,
        CMD_PROBE_SENT  = 3'd1,
        CMD_REPLY       = 3'd2,
        CMD_READ        = 3'd3,
        CMD_CLEAR_ALL   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [HOP_W-1:0]  hop_index;
        logic [LAT_W-1:0]  latency_us;
        logic [ADDR_W-1:0] responder_addr;
        logic [TYPE_W-1:0] icmp_type;
        logic [SLOT_W-1:0] history_slot;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]  sent_count;
        logic [CNT_W-1:0]  recv_count;
        logic [LAT_W-1:0]  last_latency;
        logic [LAT_W-1:0]  best_latency;
        logic [LAT_W-1:0]  worst_latency;
        logic [SUM_W-1:0]  latency_total;
        logic [SUM_W-1:0]  jitter_total;
        logic [ADDR_W-1:0] hop_addr;
        logic              seen_flag;
        logic              final_flag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_entry            entry;
        logic [LAT_W-1:0]  history_value;
        logic [DEEP_W-1:0] deepest_hop;
    } t_result;

    typedef struct packed {
        logic              entry_we;
        logic              hist_we;
        logic              clear_all;
        logic [SLOT_W-1:0] hist_slot;
        logic [DEEP_W-1:0] deepest;
    } t_upd_ctl;

endpackage

// ===== hdl/hlst_if.sv =====
`timescale 1ns / 1ps

interface hlst_in_if;
    logic                         valid;
    logic                         ready;
    logic [hlst_pkg::CMD_W-1:0]   command;
    logic [hlst_pkg::HOP_W-1:0]   hop_index;
    logic [hlst_pkg::LAT_W-1:0]   latency_us;
    logic [hlst_pkg::ADDR_W-1:0]  responder_addr;
    logic [hlst_pkg::TYPE_W-1:0]  icmp_type;
    logic [hlst_pkg::SLOT_W-1:0]  history_slot;

    modport source (
        output valid, command, hop_index, latency_us, responder_addr, icmp_type,
               history_slot,
        input  ready
    );
    modport sink (
        input  valid, command, hop_index, latency_us, responder_addr, icmp_type,
               history_slot,
        output ready
    );
endinterface

interface hlst_out_if;
    logic                         valid;
    logic                         ready;
    logic [hlst_pkg::CNT_W-1:0]   sent_count;
    logic [hlst_pkg::CNT_W-1:0]   recv_count;
    logic [hlst_pkg::LAT_W-1:0]   last_latency;
    logic [hlst_pkg::LAT_W-1:0]   best_latency;
    logic [hlst_pkg::LAT_W-1:0]   worst_latency;
    logic [hlst_pkg::SUM_W-1:0]   latency_total;
    logic [hlst_pkg::SUM_W-1:0]   jitter_total;
    logic [hlst_pkg::ADDR_W-1:0]  hop_addr;
    logic                         seen_flag;
    logic                         final_flag;
    logic [hlst_pkg::DEEP_W-1:0]  deepest_hop;
    logic [hlst_pkg::LAT_W-1:0]   history_value;

    modport source (
        output valid, sent_count, recv_count, last_latency, best_latency, worst_latency,
               latency_total, jitter_total, hop_addr, seen_flag, final_flag,
               deepest_hop, history_value,
        input  ready
    );
    modport sink (
        input  valid, sent_count, recv_count, last_latency, best_latency, worst_latency,
               latency_total, jitter_total, hop_addr, seen_flag, final_flag,
               deepest_hop, history_value,
        output ready
    );
endinterface

interface hlst_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [hlst_pkg::DEEP_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hdl/hlst_ram.sv =====
`timescale 1ns / 1ps

module hlst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hlst_update.sv =====
`timescale 1ns / 1ps

module hlst_update (
    input  hlst_pkg::t_item              i_item,
    input  hlst_pkg::t_entry             i_entry,
    input  logic [hlst_pkg::LAT_W-1:0]   i_hist,
    input  logic [hlst_pkg::DEEP_W-1:0]  i_deepest,
    input  logic [hlst_pkg::DEEP_W-1:0]  i_max_hops,
    output hlst_pkg::t_upd_ctl           o_ctl,
    output hlst_pkg::t_entry             o_entry,
    output hlst_pkg::t_result            o_result
);

    logic [hlst_pkg::LAT_W-1:0]  lat_diff;
    logic [hlst_pkg::SUM_W:0]    total_sum;
    logic [hlst_pkg::SUM_W:0]    jitter_sum;
    logic [hlst_pkg::SUM_W-1:0]  total_sat;
    logic [hlst_pkg::SUM_W-1:0]  jitter_sat;
    logic [hlst_pkg::DEEP_W-1:0] hop_num;
    logic                        dest_reached;
    logic                        slot_hit;
    logic                        slot_filled;

    assign lat_diff = (i_item.latency_us > i_entry.last_latency)
                    ? i_item.latency_us - i_entry.last_latency
                    : i_entry.last_latency - i_item.latency_us;

    assign total_sum  = {1'b0, i_entry.latency_total}
                      + {{(hlst_pkg::SUM_W + 1 - hlst_pkg::LAT_W){1'b0}}, i_item.latency_us};
    assign jitter_sum = {1'b0, i_entry.jitter_total}
                      + {{(hlst_pkg::SUM_W + 1 - hlst_pkg::LAT_W){1'b0}}, lat_diff};
    assign total_sat  = total_sum[hlst_pkg::SUM_W] ? '1 : total_sum[hlst_pkg::SUM_W-1:0];
    assign jitter_sat = jitter_sum[hlst_pkg::SUM_W] ? '1 : jitter_sum[hlst_pkg::SUM_W-1:0];

    assign hop_num      = {1'b0, i_item.hop_index} + {{(hlst_pkg::DEEP_W - 1){1'b0}}, 1'b1};
    assign dest_reached = (i_item.icmp_type == hlst_pkg::DEST_REACHED_TYPE);

    always_comb begin
        o_entry          = i_entry;
        o_ctl.entry_we   = 1'b0;
        o_ctl.hist_we    = 1'b0;
        o_ctl.clear_all  = 1'b0;
        o_ctl.hist_slot  = i_entry.recv_count[hlst_pkg::SLOT_W-1:0];
        o_ctl.deepest    = i_deepest;

        unique case (hlst_pkg::t_cmd'(i_item.command))
            hlst_pkg::CMD_ROUND_START: begin
                o_ctl.deepest = i_max_hops;
            end
            hlst_pkg::CMD_PROBE_SENT: begin
                o_ctl.entry_we = 1'b1;
                if (i_entry.sent_count != '1) begin
                    o_entry.sent_count = i_entry.sent_count + 1'b1;
                end
            end
            hlst_pkg::CMD_REPLY: begin
                o_ctl.entry_we        = 1'b1;
                o_ctl.hist_we         = 1'b1;
                o_entry.hop_addr      = i_item.responder_addr;
                o_entry.seen_flag     = 1'b1;
                o_entry.final_flag    = dest_reached;
                o_entry.last_latency  = i_item.latency_us;
                o_entry.latency_total = total_sat;
                if (i_entry.recv_count != '0) begin
                    o_entry.jitter_total = jitter_sat;
                end
                if (i_entry.recv_count != '1) begin
                    o_entry.recv_count = i_entry.recv_count + 1'b1;
                end
                if (i_entry.recv_count == '0 || i_item.latency_us < i_entry.best_latency) begin
                    o_entry.best_latency = i_item.latency_us;
                end
                if (i_item.latency_us > i_entry.worst_latency) begin
                    o_entry.worst_latency = i_item.latency_us;
                end
                if (dest_reached && hop_num < i_deepest) begin
                    o_ctl.deepest = hop_num;
                end
            end
            hlst_pkg::CMD_READ: begin
            end
            hlst_pkg::CMD_CLEAR_ALL: begin
                o_ctl.clear_all = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // A slot holds data only once the reply count since the last clear has passed it.
    assign slot_hit    = (o_ctl.hist_slot == i_item.history_slot);
    assign slot_filled = o_entry.recv_count
                       > {{(hlst_pkg::CNT_W - hlst_pkg::SLOT_W){1'b0}}, i_item.history_slot};

    always_comb begin
        o_result.entry       = o_ctl.clear_all ? '0 : o_entry;
        o_result.deepest_hop = o_ctl.deepest;
        priority if (o_ctl.clear_all) begin
            o_result.history_value = '0;
        end else if (o_ctl.hist_we && slot_hit) begin
            o_result.history_value = i_item.latency_us;
        end else if (slot_filled) begin
            o_result.history_value = i_hist;
        end else begin
            o_result.history_value = '0;
        end
    end

endmodule

// ===== hdl/hop_latency_stats_table_top.sv =====
`timescale 1ns / 1ps

// Per-hop latency statistics table for a traceroute prober: 64 hop entries, each with
// probe and reply counts, last, best and worst latency, saturating latency and jitter
// sums, responder address, flags and a 64-slot latency history. One input transaction
// can be accepted in every cycle unless the output stalls; its single result is
// computed in stage 1 and held in an output register, which lets the next one enter
// while it waits. The figure is set by one read-modify-write of the hop statistics
// memory per cycle, read at acceptance and written from the update stage, with the
// previous write forwarded. No clearing pass follows reset or clear_all: per-hop valid
// bits and the reply count mask stale memory contents, so it is ready out of reset.

module hop_latency_stats_table_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hlst_in_if.sink        i_in,
    hlst_out_if.source     o_out,
    hlst_cfg_if.sink       i_cfg
);

    logic                             in_acc;
    logic                             s1_adv;
    logic                             r_s1_valid;
    hlst_pkg::t_item                  r_item;
    hlst_pkg::t_item                  in_item;
    logic [hlst_pkg::DEEP_W-1:0]      r_max_hops;
    logic [hlst_pkg::DEEP_W-1:0]      r_deepest;
    logic [hlst_pkg::HOP_DEPTH-1:0]   r_valid;

    logic [hlst_pkg::ENTRY_W-1:0]     stats_rdata;
    logic [hlst_pkg::LAT_W-1:0]       hist_rdata;

    logic                             r_fwd_valid;
    logic [hlst_pkg::HOP_W-1:0]       r_fwd_hop;
    hlst_pkg::t_entry                 r_fwd_entry;
    logic                             r_hfwd_valid;
    logic [hlst_pkg::HIST_ADDR_W-1:0] r_hfwd_addr;
    logic [hlst_pkg::LAT_W-1:0]       r_hfwd_data;

    hlst_pkg::t_entry                 raw_entry;
    hlst_pkg::t_entry                 eff_entry;
    logic [hlst_pkg::LAT_W-1:0]       eff_hist;
    hlst_pkg::t_upd_ctl               ctl;
    hlst_pkg::t_entry                 n_entry;
    hlst_pkg::t_result                n_result;
    logic                             r_out_valid;
    hlst_pkg::t_result                r_result;
    logic [hlst_pkg::HIST_ADDR_W-1:0] hist_waddr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hops <= hlst_pkg::MAX_HOPS_RESET;
        end else if (i_cfg.valid) begin
            r_max_hops <= i_cfg.data;
        end
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    assign in_item.command        = i_in.command;
    assign in_item.hop_index      = i_in.hop_index;
    assign in_item.latency_us     = i_in.latency_us;
    assign in_item.responder_addr = i_in.responder_addr;
    assign in_item.icmp_type      = i_in.icmp_type;
    assign in_item.history_slot   = i_in.history_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc || (r_s1_valid && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= in_item;
        end
    end

    hlst_ram #(
        .WIDTH (hlst_pkg::ENTRY_W),
        .DEPTH (hlst_pkg::HOP_DEPTH)
    ) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv && ctl.entry_we),
        .i_waddr (r_item.hop_index),
        .i_wdata (n_entry),
        .i_re    (in_acc),
        .i_raddr (i_in.hop_index),
        .o_rdata (stats_rdata)
    );

    assign hist_waddr = {r_item.hop_index, ctl.hist_slot};

    hlst_ram #(
        .WIDTH (hlst_pkg::LAT_W),
        .DEPTH (hlst_pkg::HIST_ENTRIES)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv && ctl.hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (r_item.latency_us),
        .i_re    (in_acc),
        .i_raddr ({i_in.hop_index, i_in.history_slot}),
        .o_rdata (hist_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid  <= 1'b0;
            r_hfwd_valid <= 1'b0;
        end else begin
            if (s1_adv && ctl.entry_we) begin
                r_fwd_valid <= 1'b1;
            end
            if (s1_adv && ctl.hist_we) begin
                r_hfwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && ctl.entry_we) begin
            r_fwd_hop   <= r_item.hop_index;
            r_fwd_entry <= n_entry;
        end
        if (s1_adv && ctl.hist_we) begin
            r_hfwd_addr <= hist_waddr;
            r_hfwd_data <= r_item.latency_us;
        end
    end

    assign raw_entry = (r_fwd_valid && r_fwd_hop == r_item.hop_index)
                     ? r_fwd_entry : hlst_pkg::t_entry'(stats_rdata);
    assign eff_entry = r_valid[r_item.hop_index] ? raw_entry : '0;
    assign eff_hist  = (r_hfwd_valid
                        && r_hfwd_addr == {r_item.hop_index, r_item.history_slot})
                     ? r_hfwd_data : hist_rdata;

    hlst_update u_update (
        .i_item     (r_item),
        .i_entry    (eff_entry),
        .i_hist     (eff_hist),
        .i_deepest  (r_deepest),
        .i_max_hops (r_max_hops),
        .o_ctl      (ctl),
        .o_entry    (n_entry),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_deepest <= hlst_pkg::MAX_HOPS_RESET;
        end else if (s1_adv) begin
            r_deepest <= ctl.deepest;
            if (ctl.clear_all) begin
                r_valid <= '0;
            end else if (ctl.entry_we) begin
                r_valid[r_item.hop_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= s1_adv || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sent_count    = r_result.entry.sent_count;
    assign o_out.recv_count    = r_result.entry.recv_count;
    assign o_out.last_latency  = r_result.entry.last_latency;
    assign o_out.best_latency  = r_result.entry.best_latency;
    assign o_out.worst_latency = r_result.entry.worst_latency;
    assign o_out.latency_total = r_result.entry.latency_total;
    assign o_out.jitter_total  = r_result.entry.jitter_total;
    assign o_out.hop_addr      = r_result.entry.hop_addr;
    assign o_out.seen_flag     = r_result.entry.seen_flag;
    assign o_out.final_flag    = r_result.entry.final_flag;
    assign o_out.deepest_hop   = r_result.deepest_hop;
    assign o_out.history_value = r_result.history_value;

`ifndef SYNTHESIS
    a_clear_drops_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && ctl.clear_all) |=> (r_valid == '0))
        else $error("Valid bits survived a clear_all transaction.");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && ctl.entry_we && !ctl.clear_all) |=> r_valid[$past(r_item.hop_index)])
        else $error("Written hop entry is not marked valid.");

    a_deepest_only_rises_on_round_start: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (s1_adv && r_item.command != hlst_pkg::CMD_ROUND_START)
        |=> (r_deepest <= $past(r_deepest)))
        else $error("Deepest hop rose without a round_start transaction.");

    a_reply_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && ctl.hist_we) |-> (n_entry.recv_count >= eff_entry.recv_count))
        else $error("Reply count decreased on a reply transaction.");
`endif

endmodule
